// ----- hdl/pcr_pkg.sv -----
// Shared types and constants of the pretrigger capture ring.
package pcr_pkg;

   // Ring depth, a power of two of at most 256, the reach of the 8-bit read address and start index.
   localparam int DEPTH = 256;
   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W-1:0] HALF_DEPTH = IDX_W'(DEPTH / 2);
   localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(DEPTH - 1);

   // Command queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Operation codes.
   localparam logic [1:0] OP_ARM    = 2'd0;
   localparam logic [1:0] OP_STROBE = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   // Trigger modes.
   localparam logic [1:0] MODE_AUTO   = 2'd0;
   localparam logic [1:0] MODE_NORMAL = 2'd1;
   localparam logic [1:0] MODE_SINGLE = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] sample;
      logic       trigger_edge;
      logic [7:0] read_address;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       capturing;
      logic       capture_done;
      logic       was_triggered;
      logic [7:0] start_index;
      logic       enter_hold;
   } rsp_type;

   // Decoded command handed from front to back.
   typedef struct packed {
      logic       arm;
      logic       strobe;
      logic       read;
      logic [7:0] sample;
      logic       trigger_edge;
      logic [IDX_W-1:0] ring_addr;
   } cmd_type;

endpackage

// ----- hdl/pcr_front.sv -----
// Front end: accept request items and decode them into commands.
module pcr_front (
   input  logic             req_valid,
   input  pcr_pkg::req_type req_item,
   input  logic             queue_full,
   output logic             req_stall,
   output logic             cmd_push,
   output pcr_pkg::cmd_type cmd
);

   logic [31:0] addr_wide;

   // Fold the read address into the ring.
   assign addr_wide = 32'(req_item.read_address);

   always_comb begin
      cmd = '0;
      cmd.sample       = req_item.sample;
      cmd.trigger_edge = req_item.trigger_edge;
      cmd.ring_addr    = addr_wide[pcr_pkg::IDX_W-1:0];
      unique case (req_item.op)
         pcr_pkg::OP_ARM:    cmd.arm = 1'b1;
         pcr_pkg::OP_STROBE: cmd.strobe = 1'b1;
         pcr_pkg::OP_READ:   cmd.read = 1'b1;
         default:            cmd.arm = 1'b0; // status only
      endcase
   end

   assign req_stall = queue_full;
   assign cmd_push  = req_valid && !queue_full;

endmodule

// ----- hdl/pcr_queue.sv -----
// Short command queue between front and back.
module pcr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pcr_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output pcr_pkg::cmd_type head_cmd
);

   pcr_pkg::cmd_type entry_ff [pcr_pkg::QUEUE_DEPTH];
   logic [pcr_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pcr_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pcr_pkg::QCNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == pcr_pkg::QCNT_W'(pcr_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hdl/pcr_back.sv -----
// Back end: capture state, sample ring and registered result stage.
module pcr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  pcr_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pcr_pkg::rsp_type rsp_item,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_data
);

   localparam int IW = pcr_pkg::IDX_W;

   logic [7:0] ring_mem [pcr_pkg::DEPTH];

   logic [1:0]    mode_ff;
   logic [IW-1:0] write_index_ff, write_index_in;
   logic [IW-1:0] post_count_ff, post_count_in;
   logic [IW-1:0] trigger_index_ff, trigger_index_in;
   logic          running_ff, running_in;
   logic          dummy_ff, dummy_in;
   logic          pending_ff, pending_in;
   logic          triggered_ff, triggered_in;
   logic          finished_ff, finished_in;

   logic          out_valid_ff;
   logic          is_read_ff;
   logic [7:0]    read_data_ff;
   logic          capturing_ff, done_ff, was_trig_ff, hold_ff;
   logic [7:0]    start_ff;

   logic          advance;
   logic          do_strobe;
   logic          step_index;
   logic          show_trig;
   logic [IW-1:0] start_idx;
   logic [31:0]   start_wide;

   assign csr_ready = 1'b1;
   assign advance   = cmd_valid && (!out_valid_ff || !rsp_stall);
   assign cmd_pop   = advance;
   assign do_strobe = cmd.strobe && running_ff;

   always_comb begin
      write_index_in   = write_index_ff;
      post_count_in    = post_count_ff;
      trigger_index_in = trigger_index_ff;
      running_in       = running_ff;
      dummy_in         = dummy_ff;
      pending_in       = pending_ff;
      triggered_in     = triggered_ff;
      finished_in      = finished_ff;
      step_index       = 1'b0;
      if (cmd.arm) begin
         write_index_in = '0;
         dummy_in       = 1'b1;
         post_count_in  = pcr_pkg::HALF_DEPTH;
         running_in     = 1'b1;
         triggered_in   = 1'b0;
         finished_in    = 1'b0;
         pending_in     = 1'b0;
      end else if (do_strobe) begin
         pending_in = pending_ff || cmd.trigger_edge;
         if (!triggered_ff) begin
            step_index = 1'b1;
            if (pending_in && !dummy_ff) begin
               triggered_in     = 1'b1;
               trigger_index_in = write_index_ff;
            end
         end else if (post_count_ff == '0) begin
            // countdown exhausted: finish without advancing
            running_in  = 1'b0;
            finished_in = 1'b1;
         end else begin
            post_count_in = post_count_ff - 1'b1;
            step_index    = 1'b1;
         end
         if (step_index) begin
            if (write_index_ff == pcr_pkg::LAST_INDEX) begin
               write_index_in = '0;
               if (dummy_ff) begin
                  dummy_in   = 1'b0;
                  pending_in = 1'b0;
               end else if (mode_ff == pcr_pkg::MODE_AUTO) begin
                  running_in  = 1'b0;
                  finished_in = 1'b1;
               end
            end else begin
               write_index_in = write_index_ff + 1'b1;
            end
         end
      end
   end

   // Status after this item.
   assign show_trig  = finished_in && triggered_in;
   assign start_idx  = trigger_index_in - pcr_pkg::HALF_DEPTH;
   assign start_wide = 32'(start_idx);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= pcr_pkg::MODE_AUTO;
         write_index_ff   <= '0;
         post_count_ff    <= '0;
         trigger_index_ff <= '0;
         running_ff       <= 1'b0;
         dummy_ff         <= 1'b0;
         pending_ff       <= 1'b0;
         triggered_ff     <= 1'b0;
         finished_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            mode_ff <= csr_data;
         end
         if (advance) begin
            write_index_ff   <= write_index_in;
            post_count_ff    <= post_count_in;
            trigger_index_ff <= trigger_index_in;
            running_ff       <= running_in;
            dummy_ff         <= dummy_in;
            pending_ff       <= pending_in;
            triggered_ff     <= triggered_in;
            finished_ff      <= finished_in;
            out_valid_ff     <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload; loaded only when an item moves into the output stage.
   always_ff @(posedge clock) begin
      if (advance) begin
         is_read_ff   <= cmd.read;
         capturing_ff <= running_in;
         done_ff      <= finished_in;
         was_trig_ff  <= show_trig;
         start_ff     <= show_trig ? start_wide[7:0] : 8'd0;
         hold_ff      <= show_trig && (mode_ff == pcr_pkg::MODE_SINGLE);
      end
   end

   always_ff @(posedge clock) begin
      if (advance && do_strobe) begin
         ring_mem[write_index_ff] <= cmd.sample;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && cmd.read) begin
         read_data_ff <= ring_mem[cmd.ring_addr];
      end
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_item.read_data      = is_read_ff ? read_data_ff : 8'd0;
   assign rsp_item.capturing      = capturing_ff;
   assign rsp_item.capture_done   = done_ff;
   assign rsp_item.was_triggered  = was_trig_ff;
   assign rsp_item.start_index    = start_ff;
   assign rsp_item.enter_hold     = hold_ff;

endmodule

// ----- hdl/pretrigger_capture_ring_core.sv -----
// Top level of the pretrigger capture ring.

// Capture engine for a sampling scope. Each request item is one of: arm
// (restart a capture, index to 0, one dummy pass through the ring with
// trigger edges ignored), sample strobe (store the sample at the write
// index; after the dummy pass the first pending trigger edge marks the
// trigger index and starts a half-depth post-trigger countdown), or read
// (return the stored sample at the address taken modulo the depth). Every
// item yields exactly one response item showing the status after that
// item: capturing, done, triggered, the display start index (trigger index
// minus half the depth, modulo depth) and a hold request in single-shot
// mode. The ring depth is a power of two set in the package. Items enter a
// two-entry command queue and are executed by the back end one per clock
// while no response stall holds them, so the block sustains one item per
// cycle. An accepted item is written into the queue, and its response is
// registered in the output stage as the item leaves the queue. The rate is
// set by the update of the capture state and the one write or one read of
// the sample ring per item. The ring needs no clearing after reset. Write
// the trigger mode register only while the block is idle; csr_ready is
// always high.
module pretrigger_capture_ring_core (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  pcr_pkg::req_type req_item,
   // response channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pcr_pkg::rsp_type rsp_item,
   // trigger mode register
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_data
);

   pcr_pkg::cmd_type front_cmd;
   pcr_pkg::cmd_type head_cmd;
   logic             cmd_push;
   logic             cmd_pop;
   logic             queue_full;
   logic             queue_not_empty;

   // Decode and accept items while the queue has room.
   pcr_front u_front (
      .req_valid  (req_valid),
      .req_item   (req_item),
      .queue_full (queue_full),
      .req_stall  (req_stall),
      .cmd_push   (cmd_push),
      .cmd        (front_cmd)
   );

   // Decouple acceptance from execution.
   pcr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_cmd  (front_cmd),
      .pop       (cmd_pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_cmd  (head_cmd)
   );

   // Execute commands against the capture state and sample ring.
   pcr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_not_empty),
      .cmd       (head_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

endmodule

// ----- dv/tb_pretrigger_capture_ring_core.sv -----
// Testbench for the pretrigger capture ring core: directed capture runs checked per item.
`timescale 1ns / 1ps

module tb_pretrigger_capture_ring_core;

   // Op code 3 and trigger mode 3 have no package names; both are legal
   // field values and get exercised.
   localparam logic [1:0] OP_STATUS  = 2'd3;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int HALF = pcr_pkg::DEPTH / 2;
   // Cycles with no handshake on any channel before the run is abandoned.
   localparam int QUIET_LIMIT = 1000;
   localparam int PRINT_LIMIT = 100;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   pcr_pkg::req_type req_item = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   pcr_pkg::rsp_type rsp_item;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [1:0]       csr_data = '0;

   pretrigger_capture_ring_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Capture predictor: its own copy of the ring, the capture flags and
   // the trigger mode, advanced once per accepted item.
   // ------------------------------------------------------------------
   logic [7:0] ring_copy [pcr_pkg::DEPTH];
   int         wr_pos = 0;
   int         post_left = 0;
   int         trig_pos = 0;
   bit         cap_running = 1'b0;
   bit         cap_dummy = 1'b0;
   bit         cap_pending = 1'b0;
   bit         cap_triggered = 1'b0;
   bit         cap_finished = 1'b0;
   logic [1:0] mode_reg = pcr_pkg::MODE_AUTO;

   pcr_pkg::rsp_type expected_status [$];
   int         mismatches = 0;
   int         burst_left = 0;

   task automatic predict_capture(input pcr_pkg::req_type it);
      pcr_pkg::rsp_type st;
      bit      halted;
      st = '0;
      halted = 1'b0;
      case (it.op)
         pcr_pkg::OP_ARM: begin
            // restart: index to 0, one dummy pass, all capture flags cleared
            wr_pos = 0;
            cap_dummy = 1'b1;
            post_left = HALF;
            cap_running = 1'b1;
            cap_triggered = 1'b0;
            cap_finished = 1'b0;
            cap_pending = 1'b0;
         end
         pcr_pkg::OP_STROBE: begin
            if (cap_running) begin
               if (it.trigger_edge)
                  cap_pending = 1'b1;
               ring_copy[wr_pos] = it.sample;
               if (!cap_triggered) begin
                  // edges seen during the dummy pass never trigger
                  if (cap_pending && !cap_dummy) begin
                     cap_triggered = 1'b1;
                     trig_pos = wr_pos;
                  end
               end else if (post_left == 0) begin
                  // countdown spent: sample stored, index stays put
                  cap_finished = 1'b1;
                  cap_running = 1'b0;
                  halted = 1'b1;
               end else begin
                  post_left--;
               end
               if (!halted) begin
                  wr_pos++;
                  if (wr_pos >= pcr_pkg::DEPTH) begin
                     wr_pos = 0;
                     if (cap_dummy) begin
                        // end of the dummy pass drops any stale edge
                        cap_dummy = 1'b0;
                        cap_pending = 1'b0;
                     end else if (mode_reg == pcr_pkg::MODE_AUTO) begin
                        cap_finished = 1'b1;
                        cap_running = 1'b0;
                     end
                  end
               end
            end
         end
         pcr_pkg::OP_READ: st.read_data = ring_copy[it.read_address % pcr_pkg::DEPTH];
         default: ;
      endcase
      st.capturing = cap_running;
      st.capture_done = cap_finished;
      if (cap_finished && cap_triggered) begin
         st.was_triggered = 1'b1;
         st.start_index = 8'((trig_pos + pcr_pkg::DEPTH - HALF) % pcr_pkg::DEPTH);
         st.enter_hold = (mode_reg == pcr_pkg::MODE_SINGLE);
      end
      expected_status.push_back(st);
   endtask

   // ------------------------------------------------------------------
   // Mismatch reporting and response checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < PRINT_LIMIT)
         $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // Sample at the rising edge: the block's outputs still show the values
   // from before this edge, so the check does not race the design.
   always @(posedge clock) begin : check_status
      pcr_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_status.size() == 0) begin
            report_mismatch("response with nothing outstanding", 1, 0);
         end else begin
            want = expected_status.pop_front();
            if (rsp_item.read_data !== want.read_data)
               report_mismatch("read_data", rsp_item.read_data, want.read_data);
            if (rsp_item.capturing !== want.capturing)
               report_mismatch("capturing", rsp_item.capturing, want.capturing);
            if (rsp_item.capture_done !== want.capture_done)
               report_mismatch("capture_done", rsp_item.capture_done, want.capture_done);
            if (rsp_item.was_triggered !== want.was_triggered)
               report_mismatch("was_triggered", rsp_item.was_triggered, want.was_triggered);
            if (rsp_item.start_index !== want.start_index)
               report_mismatch("start_index", rsp_item.start_index, want.start_index);
            if (rsp_item.enter_hold !== want.enter_hold)
               report_mismatch("enter_hold", rsp_item.enter_hold, want.enter_hold);
         end
      end
   end

   // Receiver stall pattern: phases of random length, each with its own
   // stall density, including phases that never stall.
   int stall_pct = 0;
   int stall_phase = 0;
   always @(negedge clock) begin
      if (stall_phase == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 50;
            default: stall_pct = 85;
         endcase
         stall_phase = $urandom_range(20, 250);
      end
      stall_phase--;
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Watchdog: abort when no handshake happens anywhere for too long.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
          (csr_valid && csr_ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------
   function automatic pcr_pkg::req_type make_item(input logic [1:0] op, input logic [7:0] smp,
                                                  input logic edge_bit, input logic [7:0] addr);
      pcr_pkg::req_type it;
      it.op = op;
      it.sample = smp;
      it.trigger_edge = edge_bit;
      it.read_address = addr;
      return it;
   endfunction

   // Send one item in bursts with random gaps; hold valid and payload
   // until the block takes it, then advance the predictor.
   task automatic send_item(input pcr_pkg::req_type it);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 4) == 0) begin
            gap = 0;
            burst_left = $urandom_range(100, 300);
         end else begin
            gap = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
         end
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_capture(it);
   endtask

   // Drop valid and wait until every outstanding response has come back.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_status.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_trigger_mode(input logic [1:0] mode);
      drain_results();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= mode;
      do @(posedge clock); while (csr_ready !== 1'b1);
      mode_reg = mode;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic arm_capture();
      send_item(make_item(pcr_pkg::OP_ARM, 8'($urandom), 1'($urandom), 8'($urandom)));
   endtask

   // n strobes with random samples; the edge is raised only on strobe
   // number edge_at (none when negative).
   task automatic strobe_run(input int n, input int edge_at);
      for (int k = 0; k < n; k++)
         send_item(make_item(pcr_pkg::OP_STROBE, 8'($urandom), k == edge_at, 8'($urandom)));
   endtask

   task automatic read_entry(input logic [7:0] addr);
      send_item(make_item(pcr_pkg::OP_READ, 8'($urandom), 1'($urandom), addr));
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Status before any arm; a strobe here must be ignored.
   task automatic test_idle_status();
      send_item(make_item(OP_STATUS, 8'hFF, 1'b1, 8'hFF));
      send_item(make_item(pcr_pkg::OP_STROBE, 8'hFF, 1'b1, 8'hFF));
      send_item(make_item(OP_STATUS, 8'h00, 1'b0, 8'h00));
   endtask

   // Normal mode: the dummy pass fills the ring, edges there never count,
   // including an edge on the very strobe that wraps the index.
   task automatic test_dummy_pass();
      logic [7:0] smp;
      write_trigger_mode(pcr_pkg::MODE_NORMAL);
      arm_capture();
      for (int k = 0; k < pcr_pkg::DEPTH; k++) begin
         smp = (k == 0) ? 8'hFF : (k == pcr_pkg::DEPTH - 1) ? 8'h00 : 8'($urandom);
         send_item(make_item(pcr_pkg::OP_STROBE, smp,
                             (k % 37 == 0) || (k == pcr_pkg::DEPTH - 1), 8'($urandom)));
      end
      read_entry(8'h00);
      read_entry(8'hFF);
      // pending edge from the last dummy strobe was dropped at the wrap
      strobe_run(1, -1);
   endtask

   // Mode 3 acts as normal mode. Continue the capture left by the dummy
   // pass: trigger on the next strobe, run the countdown out, then the
   // strobe that finds it spent finishes the capture with no hold request.
   task automatic test_post_trigger_countdown();
      write_trigger_mode(MODE_SPARE);
      strobe_run(1, 0);
      strobe_run(HALF, -1);
      strobe_run(1, -1);
      send_item(make_item(pcr_pkg::OP_STROBE, 8'hA5, 1'b1, 8'h5A));
      read_entry(8'h00);
      send_item(make_item(OP_STATUS, 8'h00, 1'b0, 8'h00));
   endtask

   // Single shot: trigger just below half depth so the start index is the
   // last entry, countdown crosses the wrap without finishing, hold raised.
   task automatic test_single_shot_hold();
      write_trigger_mode(pcr_pkg::MODE_SINGLE);
      arm_capture();
      strobe_run(pcr_pkg::DEPTH, -1);
      strobe_run(HALF, HALF - 1);
      strobe_run(HALF + 1, -1);
      strobe_run(1, 0);
      read_entry(8'($urandom));
   endtask

   // Auto mode: an arm in the middle of the dummy pass restarts it, and a
   // trigger late in the first pass after it is cut short by the wrap.
   task automatic test_auto_wrap();
      write_trigger_mode(pcr_pkg::MODE_AUTO);
      arm_capture();
      strobe_run(20, 5);
      arm_capture();
      strobe_run(pcr_pkg::DEPTH, pcr_pkg::DEPTH - 1);
      strobe_run(201, 200);
      strobe_run(pcr_pkg::DEPTH - 201, -1);
      read_entry(8'($urandom));
      send_item(make_item(OP_STATUS, 8'($urandom), 1'($urandom), 8'($urandom)));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_status();
      test_dummy_pass();
      test_post_trigger_countdown();
      test_single_shot_hold();
      test_auto_wrap();

      drain_results();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
